// ===== design/pld_pkg.sv =====
// pld_pkg: shared types and constants of the posting list decoder
// transaction structs, opcode and status codes, internal stage structs
// no dependencies
`default_nettype none

package pld_pkg;

  localparam int unsigned PLD_MAX_DOCS = 65536;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;

  localparam logic [1:0] ST_POSTING   = 2'd0;
  localparam logic [1:0] ST_LIST_END  = 2'd1;
  localparam logic [1:0] ST_AFTER_END = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  stream_byte;
    logic [31:0] term_doc_count;
    logic [31:0] segment_base;
    logic [15:0] deleted_doc;
  } pld_in_t;

  typedef struct packed {
    logic [31:0] doc_number;
    logic [31:0] frequency;
    logic        last;
    logic [1:0]  status;
  } pld_out_t;

  // deleted map access from the decode stage
  typedef struct packed {
    logic        mark_en;
    logic [15:0] mark_doc;
    logic        look_en;
    logic [31:0] look_doc;
  } map_req_t;

  // candidate result between decode and result register
  typedef struct packed {
    logic        after_end;
    logic        closes;
    logic [31:0] doc;
    logic [31:0] base;
    logic [31:0] freq;
  } pend_t;

endpackage

`default_nettype wire

// ===== design/pld_decode.sv =====
// pld_decode: input register, varint decode and running document state
// depends on pld_pkg; feeds pld_del_map and pld_out_stage
`default_nettype none

module pld_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire pld_pkg::pld_in_t  in_data,
  output logic                   in_stall,
  input  wire logic              map_busy,
  input  wire logic              out_ready,
  output pld_pkg::map_req_t      map_req,
  output logic                   pend_valid_r,
  output pld_pkg::pend_t         pend_r
);
  import pld_pkg::*;

  logic        in_valid_r;
  pld_in_t     in_r;
  logic        p_free;
  logic        adv;

  logic [31:0] accum_r, accum_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        expect_r, expect_nxt;
  logic [31:0] running_r, running_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] base_r, base_nxt;

  logic [31:0] grp;
  logic [31:0] value;
  logic [31:0] seen_inc;
  logic        at_end;
  logic        finish;
  logic        has_pend;
  pend_t       pend_nxt;

  assign p_free   = !pend_valid_r || out_ready;
  assign adv      = in_valid_r && p_free;
  assign in_stall = map_busy || (in_valid_r && !p_free);

  assign seen_inc = seen_r + 32'd1;
  assign at_end   = (seen_r == total_r);

  always_comb begin
    case (idx_r)
      3'd0:    grp = {25'd0, in_r.stream_byte[6:0]};
      3'd1:    grp = {18'd0, in_r.stream_byte[6:0], 7'd0};
      3'd2:    grp = {11'd0, in_r.stream_byte[6:0], 14'd0};
      3'd3:    grp = {4'd0, in_r.stream_byte[6:0], 21'd0};
      3'd4:    grp = {in_r.stream_byte[3:0], 28'd0};
      default: grp = 32'd0;
    endcase
  end

  assign value = accum_r | grp;

  always_comb begin
    accum_nxt   = accum_r;
    idx_nxt     = idx_r;
    expect_nxt  = expect_r;
    running_nxt = running_r;
    seen_nxt    = seen_r;
    total_nxt   = total_r;
    base_nxt    = base_r;
    finish      = 1'b0;
    has_pend    = 1'b0;
    pend_nxt.after_end = 1'b0;
    pend_nxt.closes    = 1'b0;
    pend_nxt.freq      = 32'd1;
    unique case (in_r.opcode)
      OP_START: begin
        total_nxt   = in_r.term_doc_count;
        base_nxt    = in_r.segment_base;
        accum_nxt   = 32'd0;
        idx_nxt     = 3'd0;
        expect_nxt  = 1'b0;
        running_nxt = 32'd0;
        seen_nxt    = 32'd0;
      end
      OP_BYTE: begin
        if (at_end) begin
          has_pend           = 1'b1;
          pend_nxt.after_end = 1'b1;
        end else if (in_r.stream_byte[7]) begin
          accum_nxt = value;
          idx_nxt   = (idx_r == 3'd7) ? 3'd7 : idx_r + 3'd1;
        end else begin
          accum_nxt = 32'd0;
          idx_nxt   = 3'd0;
          if (expect_r) begin
            expect_nxt    = 1'b0;
            finish        = 1'b1;
            pend_nxt.freq = value;
          end else begin
            running_nxt = running_r + {1'b0, value[31:1]};
            if (value[0]) begin
              finish = 1'b1;
            end else begin
              expect_nxt = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    if (finish) begin
      seen_nxt        = seen_inc;
      has_pend        = 1'b1;
      pend_nxt.closes = (seen_inc == total_r);
    end
    pend_nxt.doc  = running_nxt;
    pend_nxt.base = base_r;
  end

  assign map_req.mark_en  = adv && (in_r.opcode == OP_MARK);
  assign map_req.mark_doc = in_r.deleted_doc;
  assign map_req.look_en  = adv;
  assign map_req.look_doc = running_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      accum_r      <= '0;
      idx_r        <= '0;
      expect_r     <= 1'b0;
      running_r    <= '0;
      seen_r       <= '0;
      total_r      <= '0;
      base_r       <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (p_free) begin
        pend_valid_r <= adv && has_pend;
      end
      if (adv) begin
        accum_r   <= accum_nxt;
        idx_r     <= idx_nxt;
        expect_r  <= expect_nxt;
        running_r <= running_nxt;
        seen_r    <= seen_nxt;
        total_r   <= total_nxt;
        base_r    <= base_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
    if (adv && has_pend) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/pld_del_map.sv =====
// pld_del_map: deleted document bitmap memory with clearing sweep after reset
// depends on pld_pkg; one write and one registered read per cycle
`default_nettype none

module pld_del_map #(
  parameter int unsigned MAX_DOCS = pld_pkg::PLD_MAX_DOCS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pld_pkg::map_req_t map_req,
  output logic                   busy,
  output logic                   deleted
);
  import pld_pkg::*;

  localparam int unsigned AW = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;

  logic          del_mem_r [MAX_DOCS];
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;
  logic          rd_r;
  logic          rd_in_map_r;

  logic [31:0]   mark_ext;
  logic          mark_in_map;
  logic          look_in_map;

  assign mark_ext    = 32'(map_req.mark_doc);
  assign mark_in_map = mark_ext < 32'(MAX_DOCS);
  assign look_in_map = map_req.look_doc < 32'(MAX_DOCS);
  assign busy        = clr_busy_r;
  assign deleted     = rd_r && rd_in_map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == AW'(MAX_DOCS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      del_mem_r[clr_cnt_r] <= 1'b0;
    end else if (map_req.mark_en && mark_in_map) begin
      del_mem_r[mark_ext[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (map_req.look_en) begin
      rd_r        <= del_mem_r[map_req.look_doc[AW-1:0]];
      rd_in_map_r <= look_in_map;
    end
  end

endmodule

`default_nettype wire

// ===== design/pld_out_stage.sv =====
// pld_out_stage: forms the result from a decoded posting and the map lookup
// depends on pld_pkg; holds the result register of the out channel
`default_nettype none

module pld_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pend_valid,
  input  wire pld_pkg::pend_t   pend,
  input  wire logic             deleted,
  output logic                  out_ready,
  output logic                  out_valid,
  output pld_pkg::pld_out_t     out_data,
  input  wire logic             out_stall
);
  import pld_pkg::*;

  logic     out_valid_r;
  pld_out_t out_data_r;
  logic     has_res;
  pld_out_t res;

  assign out_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    has_res        = 1'b1;
    res.doc_number = 32'd0;
    res.frequency  = 32'd0;
    res.last       = 1'b0;
    res.status     = ST_AFTER_END;
    if (!pend.after_end) begin
      if (!deleted) begin
        res.doc_number = pend.base + pend.doc;
        res.frequency  = pend.freq;
        res.last       = pend.closes;
        res.status     = ST_POSTING;
      end else begin
        has_res    = pend.closes;
        res.last   = 1'b1;
        res.status = ST_LIST_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= pend_valid && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && pend_valid && has_res) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/posting_list_decoder.sv =====
// posting_list_decoder: top level of the postings stream decoder
// depends on pld_pkg, pld_decode, pld_del_map, pld_out_stage
//
//   channel | ports                          | payload
//   in      | in_valid, in_stall, in_data    | pld_in_t: opcode, byte, count, base, doc
//   out     | out_valid, out_stall, out_data | pld_out_t: doc, frequency, last, status
//
// one transaction per cycle sustained while in_stall is low; a result passes each stage below before it is valid
// stages: input register, decode with bitmap read, result register
// after reset the bitmap is swept clear with in_stall high
// out_stall holds the result register and backs up through the stages to in_stall
`default_nettype none

module posting_list_decoder #(
  parameter int unsigned MAX_DOCS = pld_pkg::PLD_MAX_DOCS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire pld_pkg::pld_in_t  in_data,
  output logic                   in_stall,
  output logic                   out_valid,
  output pld_pkg::pld_out_t      out_data,
  input  wire logic              out_stall
);
  import pld_pkg::*;

  map_req_t map_req;
  logic     map_busy;
  logic     deleted;
  logic     out_ready;
  logic     pend_valid;
  pend_t    pend;

  pld_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .in_stall     (in_stall),
    .map_busy     (map_busy),
    .out_ready    (out_ready),
    .map_req      (map_req),
    .pend_valid_r (pend_valid),
    .pend_r       (pend)
  );

  pld_del_map #(
    .MAX_DOCS (MAX_DOCS)
  ) u_del_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .map_req (map_req),
    .busy    (map_busy),
    .deleted (deleted)
  );

  pld_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .pend_valid (pend_valid),
    .pend       (pend),
    .deleted    (deleted),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule

`default_nettype wire

// ===== design/pld_checker.sv =====
// pld_checker: port level assertions for posting_list_decoder
// depends on pld_pkg; attached to the top level by the bind below
`default_nettype none

module pld_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire pld_pkg::pld_out_t out_data,
  input wire logic              out_stall
);
  import pld_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_AFTER_END |->
      out_data.doc_number == 32'd0 && out_data.frequency == 32'd0 && !out_data.last)
    else $error("ignored byte result not cleared");

  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_LIST_END |->
      out_data.last && out_data.doc_number == 32'd0 && out_data.frequency == 32'd0)
    else $error("list end result malformed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_POSTING || out_data.status == ST_LIST_END ||
      out_data.status == ST_AFTER_END)
    else $error("undefined status");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("result or input open right after reset");

endmodule

bind posting_list_decoder pld_checker u_pld_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall)
);

`default_nettype wire
